// ===== rtl/core/cbfq_pkg.sv =====
// Shared types and constants for the coalescing bounded frame queue.
package cbfq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int CFG_W       = 5;
   localparam int TAG_W       = 32;
   localparam int CHAN_W      = 16;
   localparam int ENTRY_W     = TAG_W + CHAN_W + 1;
   localparam int REQ_DATA_W  = 48;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 112;

   localparam logic [1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [1:0] MODE_POP     = 2'd1;
   localparam logic [1:0] MODE_CLEAR   = 2'd2;

   localparam logic [CFG_W-1:0] DEPTH_CAP_RESET = CFG_W'(QUEUE_DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_APPEND,
      OP_OVERWRITE,
      OP_POP
   } op_type;

endpackage

// ===== rtl/core/coalescing_bounded_frame_queue.sv =====
// Top level of the coalescing bounded frame queue.
//
// Requests arrive on req_* (stream handshake): tuser carries the mode (enqueue,
// pop, clear) and the replace-latest flag, tdata the frame tag and channel.
// Every request yields exactly one response on rsp_*, holding the enqueue
// outcome flags, the depth after the operation, the overwritten frame and
// the popped frame; fields that do not apply to the mode are zero.
// The frame store is a circular buffer in one RAM (tag, channel, flag);
// channel ids and flags are mirrored in flops for a combinational compare of
// all entries. A request is looked up and its RAM read issued in the accept
// cycle; ST_FINISH then writes the RAM and loads the response register once
// that register is free. A new request is taken only after the previous one
// has committed, since each request reads and then writes the RAM.
// If rsp_tready is low, the finished response holds in the output register;
// the next request is still taken, and its commit waits for the register.
// csr_* writes the depth cap (0 acts as 1, above 16 saturates); write it only
// while idle. Synchronous reset empties the queue and sets the depth cap to 16.
module coalescing_bounded_frame_queue
   import cbfq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] frame_tag, [47:32] channel
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] mode, [2] latest_only
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] accepted, [1] replaced, [2] overflow, [7:3] depth, [39:8] old_tag,
   // [55:40] old_channel, [56] popped_valid, [88:57] popped_tag,
   // [104:89] popped_channel, [105] popped_latest_only, [111:106] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_data
);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [CFG_W-1:0]       depth_cap_ff;
   logic [CHAN_W-1:0]      cam_chan_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cam_flag_ff;

   op_type                 op_ff, op_in;
   logic                   overflow_ff, overflow_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic [CNT_W-1:0]       depth_ff, depth_in;
   logic [TAG_W-1:0]       tag_ff;
   logic [CHAN_W-1:0]      chan_ff;
   logic                   rl_ff;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   logic                   accept;
   logic                   commit;
   logic [1:0]             req_mode;
   logic [TAG_W-1:0]       req_tag;
   logic [CHAN_W-1:0]      req_chan;
   logic                   req_rl;

   logic [CNT_W-1:0]       eff_depth;
   logic [QUEUE_DEPTH-1:0] hit_chan, hit_any, rot_chan, rot_any;
   logic                   found_chan, found_any;
   logic [IDX_W-1:0]       slot_chan, slot_any;

   logic                   ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [ENTRY_W-1:0]     ram_wr_data, ram_rd_data;

   assign req_mode  = req_tuser[1:0];
   assign req_rl    = req_tuser[2];
   assign req_tag   = req_tdata[TAG_W-1:0];
   assign req_chan  = req_tdata[TAG_W+CHAN_W-1:TAG_W];
   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // Effective depth: zero acts as one, saturate at the store size.
   always_comb begin
      if (depth_cap_ff == '0) begin
         eff_depth = CNT_W'(1);
      end else if (CNT_W'(depth_cap_ff) > CNT_W'(QUEUE_DEPTH)) begin
         eff_depth = CNT_W'(QUEUE_DEPTH);
      end else begin
         eff_depth = CNT_W'(depth_cap_ff);
      end
   end

   // Compare all entries, rotate to arrival order and pick the oldest hit.
   always_comb begin
      logic [IDX_W-1:0] lpos;
      logic [IDX_W-1:0] phys;
      logic             occ;
      for (int p = 0; p < QUEUE_DEPTH; p++) begin
         lpos        = IDX_W'(p) - head_ff;
         occ         = {1'b0, lpos} < count_ff;
         hit_any[p]  = occ && cam_flag_ff[p];
         hit_chan[p] = hit_any[p] && (cam_chan_ff[p] == req_chan);
      end
      for (int l = 0; l < QUEUE_DEPTH; l++) begin
         phys        = head_ff + IDX_W'(l);
         rot_chan[l] = hit_chan[phys];
         rot_any[l]  = hit_any[phys];
      end
      found_chan = 1'b0;
      found_any  = 1'b0;
      slot_chan  = '0;
      slot_any   = '0;
      for (int l = QUEUE_DEPTH - 1; l >= 0; l--) begin
         if (rot_chan[l]) begin
            found_chan = 1'b1;
            slot_chan  = head_ff + IDX_W'(l);
         end
         if (rot_any[l]) begin
            found_any = 1'b1;
            slot_any  = head_ff + IDX_W'(l);
         end
      end
   end

   // Decide the operation in the accept cycle and issue the RAM read.
   always_comb begin
      op_in       = OP_NONE;
      overflow_in = 1'b0;
      addr_in     = head_ff;
      depth_in    = count_ff;
      case (req_mode)
         MODE_ENQUEUE: begin
            if (req_rl && found_chan) begin
               op_in   = OP_OVERWRITE;
               addr_in = slot_chan;
            end else if (count_ff < eff_depth) begin
               op_in    = OP_APPEND;
               addr_in  = head_ff + count_ff[IDX_W-1:0];
               depth_in = count_ff + CNT_W'(1);
            end else begin
               overflow_in = 1'b1;
               if (req_rl && found_any) begin
                  op_in   = OP_OVERWRITE;
                  addr_in = slot_any;
               end
            end
         end
         MODE_POP: begin
            if (count_ff != '0) begin
               op_in    = OP_POP;
               depth_in = count_ff - CNT_W'(1);
            end
         end
         MODE_CLEAR: begin
            depth_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign ram_rd_en   = accept;
   assign ram_rd_addr = addr_in;
   assign ram_wr_en   = commit && (op_ff == OP_APPEND || op_ff == OP_OVERWRITE);
   assign ram_wr_data = {rl_ff, chan_ff, tag_ff};

   cbfq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer, response build and queue pointer update.
   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      commit        = 1'b0;
      count_in      = count_ff;
      head_in       = head_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               commit        = 1'b1;
               state_in      = ST_IDLE;
               rsp_tvalid_in = 1'b1;
               count_in      = depth_ff;
               rsp_tdata_in  = '0;
               rsp_tdata_in[0]   = (op_ff == OP_APPEND) || (op_ff == OP_OVERWRITE);
               rsp_tdata_in[1]   = (op_ff == OP_OVERWRITE);
               rsp_tdata_in[2]   = overflow_ff;
               rsp_tdata_in[7:3] = depth_ff;
               if (op_ff == OP_OVERWRITE) begin
                  rsp_tdata_in[39:8]  = ram_rd_data[TAG_W-1:0];
                  rsp_tdata_in[55:40] = ram_rd_data[TAG_W+CHAN_W-1:TAG_W];
               end
               if (op_ff == OP_POP) begin
                  head_in              = head_ff + IDX_W'(1);
                  rsp_tdata_in[56]     = 1'b1;
                  rsp_tdata_in[88:57]  = ram_rd_data[TAG_W-1:0];
                  rsp_tdata_in[104:89] = ram_rd_data[TAG_W+CHAN_W-1:TAG_W];
                  rsp_tdata_in[105]    = ram_rd_data[ENTRY_W-1];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         head_ff       <= '0;
         depth_cap_ff  <= DEPTH_CAP_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            depth_cap_ff <= csr_data;
         end
      end
   end

   // Request hold registers and the compare mirror of the RAM.
   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      if (accept) begin
         op_ff       <= op_in;
         overflow_ff <= overflow_in;
         addr_ff     <= addr_in;
         depth_ff    <= depth_in;
         tag_ff      <= req_tag;
         chan_ff     <= req_chan;
         rl_ff       <= req_rl;
      end
      if (ram_wr_en) begin
         cam_chan_ff[addr_ff] <= chan_ff;
         cam_flag_ff[addr_ff] <= rl_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== rtl/core/cbfq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cbfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/coalescing_bounded_frame_queue_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the coalescing bounded frame queue: tracks the queue, compares responses.
module coalescing_bounded_frame_queue_checker
   import cbfq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_data,
   output int unsigned           failures,
   output int unsigned           awaiting
);

   typedef struct packed {
      logic              accepted;
      logic              replaced;
      logic              overflow;
      logic [CNT_W-1:0]  depth;
      logic [TAG_W-1:0]  old_tag;
      logic [CHAN_W-1:0] old_channel;
      logic              popped_valid;
      logic [TAG_W-1:0]  popped_tag;
      logic [CHAN_W-1:0] popped_channel;
      logic              popped_latest_only;
   } queue_outcome_type;

   logic [TAG_W-1:0]  held_tags  [QUEUE_DEPTH];
   logic [CHAN_W-1:0] held_chans [QUEUE_DEPTH];
   logic              held_flags [QUEUE_DEPTH];
   int unsigned       held_count = 0;
   logic [CFG_W-1:0]  depth_limit_reg = DEPTH_CAP_RESET;
   queue_outcome_type pending_outcomes[$];
   int unsigned       mismatch_total = 0;

   // Oldest replace-latest entry, optionally restricted to one channel; held_count if none.
   function automatic int unsigned oldest_replaceable(logic same_chan, logic [CHAN_W-1:0] chan);
      for (int i = 0; i < held_count; i++) begin
         if (held_flags[i] && (!same_chan || held_chans[i] == chan))
            return i;
      end
      return held_count;
   endfunction

   function automatic queue_outcome_type overwrite_entry(queue_outcome_type o,
                                                         int unsigned slot,
                                                         logic [TAG_W-1:0] tag,
                                                         logic [CHAN_W-1:0] chan);
      o.accepted    = 1'b1;
      o.replaced    = 1'b1;
      o.old_tag     = held_tags[slot];
      o.old_channel = held_chans[slot];
      held_tags[slot]  = tag;
      held_chans[slot] = chan;
      held_flags[slot] = 1'b1;
      return o;
   endfunction

   function automatic queue_outcome_type apply_request(logic [1:0] mode, logic [TAG_W-1:0] tag,
                                                       logic [CHAN_W-1:0] chan, logic rl);
      queue_outcome_type o;
      int unsigned       limit;
      int unsigned       slot;
      o = '0;
      if (depth_limit_reg == 0)
         limit = 1;
      else if (depth_limit_reg > QUEUE_DEPTH)
         limit = QUEUE_DEPTH;
      else
         limit = 32'(depth_limit_reg);
      case (mode)
         MODE_ENQUEUE: begin
            slot = rl ? oldest_replaceable(1'b1, chan) : held_count;
            if (slot < held_count) begin
               o = overwrite_entry(o, slot, tag, chan);
            end else if (held_count < limit) begin
               held_tags[held_count]  = tag;
               held_chans[held_count] = chan;
               held_flags[held_count] = rl;
               held_count++;
               o.accepted = 1'b1;
            end else begin
               // full: a replace-latest frame may still take the oldest replaceable slot
               o.overflow = 1'b1;
               if (rl) begin
                  slot = oldest_replaceable(1'b0, chan);
                  if (slot < held_count)
                     o = overwrite_entry(o, slot, tag, chan);
               end
            end
         end
         MODE_POP: begin
            if (held_count > 0) begin
               o.popped_valid       = 1'b1;
               o.popped_tag         = held_tags[0];
               o.popped_channel     = held_chans[0];
               o.popped_latest_only = held_flags[0];
               for (int i = 1; i < held_count; i++) begin
                  held_tags[i-1]  = held_tags[i];
                  held_chans[i-1] = held_chans[i];
                  held_flags[i-1] = held_flags[i];
               end
               held_count--;
            end
         end
         MODE_CLEAR: begin
            held_count = 0;
         end
         default: ;
      endcase
      o.depth = CNT_W'(held_count);
      return o;
   endfunction

   task automatic check_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
      if (want !== got) begin
         mismatch_total++;
         if (mismatch_total <= 10)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      queue_outcome_type want;
      if (reset) begin
         held_count      = 0;
         depth_limit_reg = DEPTH_CAP_RESET;
         pending_outcomes.delete();
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            held_tags[i]  = '0;
            held_chans[i] = '0;
            held_flags[i] = 1'b0;
         end
      end else begin
         // compare first: a response never belongs to a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: response 0x%0h with no request outstanding", $time, rsp_tdata);
            end else begin
               want = pending_outcomes[0];
               pending_outcomes.delete(0);
               check_field("accepted", TAG_W'(want.accepted), TAG_W'(rsp_tdata[0]));
               check_field("replaced", TAG_W'(want.replaced), TAG_W'(rsp_tdata[1]));
               check_field("overflow", TAG_W'(want.overflow), TAG_W'(rsp_tdata[2]));
               check_field("depth", TAG_W'(want.depth), TAG_W'(rsp_tdata[7:3]));
               check_field("old_tag", want.old_tag, rsp_tdata[39:8]);
               check_field("old_channel", TAG_W'(want.old_channel), TAG_W'(rsp_tdata[55:40]));
               check_field("popped_valid", TAG_W'(want.popped_valid), TAG_W'(rsp_tdata[56]));
               check_field("popped_tag", want.popped_tag, rsp_tdata[88:57]);
               check_field("popped_channel", TAG_W'(want.popped_channel),
                           TAG_W'(rsp_tdata[104:89]));
               check_field("popped_latest_only", TAG_W'(want.popped_latest_only),
                           TAG_W'(rsp_tdata[105]));
            end
         end
         if (req_tvalid && req_tready)
            pending_outcomes.insert(pending_outcomes.size(),
                                    apply_request(req_tuser[1:0], req_tdata[31:0],
                                                  req_tdata[47:32], req_tuser[2]));
         if (csr_valid && csr_ready)
            depth_limit_reg = csr_data;
      end
      failures <= mismatch_total;
      awaiting <= pending_outcomes.size();
   end

endmodule

// ===== test/coalescing_bounded_frame_queue_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the coalescing bounded frame queue: stimulus, flow control and verdict.
module coalescing_bounded_frame_queue_tb;
   import cbfq_pkg::*;

   localparam logic [1:0]  MODE_UNUSED      = 2'd3;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned ITEMS_PER_PHASE  = 230;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data = '0;
   logic                  rsp_hold = 1'b0;
   int unsigned           send_idle_pct = 0;
   int unsigned           recv_stall_pct = 0;
   int unsigned           failures;
   int unsigned           awaiting;
   logic [CHAN_W-1:0]     chan_pool [4];
   event                  long_hold_start;

   coalescing_bounded_frame_queue u_top (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_data
   );

   coalescing_bounded_frame_queue_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_data,
      .failures, .awaiting
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // Hold off the response side for a fixed stretch so the block backs up.
   always begin
      @(long_hold_start);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic offer_request(logic [1:0] mode, logic [TAG_W-1:0] tag,
                                logic [CHAN_W-1:0] chan, logic rl);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40)
         gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {chan, tag};
      req_tuser  <= {rl, mode};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic write_depth_cap(logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic offer_random_item(int unsigned enqueue_pct);
      int unsigned       pick;
      logic [1:0]        mode;
      logic [CHAN_W-1:0] chan;
      pick = $urandom_range(99);
      if (pick < enqueue_pct)
         mode = MODE_ENQUEUE;
      else if (pick < 96)
         mode = MODE_POP;
      else if (pick < 98)
         mode = MODE_CLEAR;
      else
         mode = MODE_UNUSED;
      // mostly a small channel set so same-channel replacement happens often
      chan = ($urandom_range(9) == 0) ? CHAN_W'($urandom) : chan_pool[$urandom_range(3)];
      offer_request(mode, $urandom, chan, 1'($urandom_range(1)));
   endtask

   task automatic run_phase(logic [CFG_W-1:0] depth_value, int unsigned idle_pct,
                            int unsigned stall_pct, int unsigned enqueue_pct,
                            logic long_hold, logic pause_midway);
      wait_until_drained();
      write_depth_cap(depth_value);
      foreach (chan_pool[i]) chan_pool[i] = CHAN_W'($urandom);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      if (long_hold) begin
         ->long_hold_start;
         repeat (24) offer_request(MODE_ENQUEUE, $urandom, chan_pool[$urandom_range(3)],
                                   1'($urandom_range(1)));
      end
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (pause_midway) begin
         repeat (ITEMS_PER_PHASE / 2) offer_random_item(enqueue_pct);
         wait_until_drained();
         repeat (ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2) offer_random_item(enqueue_pct);
      end else begin
         repeat (ITEMS_PER_PHASE) offer_random_item(enqueue_pct);
      end
   endtask

   initial begin
      foreach (chan_pool[i]) chan_pool[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      offer_request(MODE_POP, '0, '0, 1'b0);
      offer_request(MODE_ENQUEUE, 32'h0000_0000, 16'h0000, 1'b0);
      offer_request(MODE_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      offer_request(MODE_ENQUEUE, 32'h1234_5678, 16'hFFFF, 1'b1);
      offer_request(MODE_ENQUEUE, 32'hA5A5_5A5A, 16'h0000, 1'b1);
      offer_request(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      offer_request(MODE_POP, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      offer_request(MODE_CLEAR, '0, '0, 1'b0);
      offer_request(MODE_POP, '0, '0, 1'b0);

      // depth of two: fill, overflow, then replacement while full
      wait_until_drained();
      write_depth_cap(5'd2);
      offer_request(MODE_ENQUEUE, 32'h0000_0001, 16'h0003, 1'b0);
      offer_request(MODE_ENQUEUE, 32'h0000_0002, 16'h0005, 1'b1);
      offer_request(MODE_ENQUEUE, 32'h0000_0003, 16'h0005, 1'b0);
      offer_request(MODE_ENQUEUE, 32'h0000_0004, 16'h0007, 1'b1);
      offer_request(MODE_ENQUEUE, 32'h0000_0005, 16'h0007, 1'b1);

      // zero acts as one, and the queue already holds two
      wait_until_drained();
      write_depth_cap(5'd0);
      offer_request(MODE_ENQUEUE, 32'h0000_0006, 16'h0009, 1'b0);
      offer_request(MODE_POP, '0, '0, 1'b0);
      offer_request(MODE_POP, '0, '0, 1'b0);
      offer_request(MODE_ENQUEUE, 32'h0000_0007, 16'h0009, 1'b0);
      offer_request(MODE_ENQUEUE, 32'h0000_0008, 16'h0009, 1'b1);

      run_phase(5'd16, 0, 0, 60, 1'b0, 1'b0);
      run_phase(5'd1, 59, 0, 55, 1'b0, 1'b0);
      run_phase(5'd4, 0, 59, 50, 1'b0, 1'b0);
      run_phase(5'd31, 24, 24, 60, 1'b1, 1'b0);
      run_phase(5'd0, 0, 0, 55, 1'b0, 1'b0);
      run_phase(5'd7, 59, 0, 45, 1'b0, 1'b0);
      run_phase(5'd16, 0, 59, 60, 1'b0, 1'b1);
      run_phase(CFG_W'($urandom_range(31)), 24, 24, 55, 1'b0, 1'b0);

      wait_until_drained();
      repeat (8) @(posedge clock);
      if (failures == 0 && awaiting == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== coalescing_bounded_frame_queue.f =====
rtl/core/cbfq_pkg.sv
rtl/core/cbfq_ram.sv
rtl/core/coalescing_bounded_frame_queue.sv
test/coalescing_bounded_frame_queue_checker.sv
test/coalescing_bounded_frame_queue_tb.sv
